// ----- src/lqt_pkg.sv -----
// shared types, constants and helper functions for the link quality table
`default_nettype none

package lqt_pkg;

	// default sizing
	localparam int NEIGHBOR_COUNT = 16;
	localparam int FRACTION_BITS  = 8;
	localparam int MARGIN_W       = 16;
	localparam int MASK_W         = 16;
	localparam int QUEUE_DEPTH    = 2;
	localparam int REG_IDX_W      = 3;

	// operation codes
	localparam logic [1:0] OP_REPORT      = 2'd0;
	localparam logic [1:0] OP_TICK        = 2'd1;
	localparam logic [1:0] OP_ROUTE_WRITE = 2'd2;
	localparam logic [1:0] OP_ROUTE_READ  = 2'd3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_HIGH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_MID  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_LOW  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_SHIFT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_AGE_LIMIT      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COST_TABLE     = 3'd5;

	// configuration reset values
	localparam logic [15:0] THRESHOLD_HIGH_RST = 16'd20;
	localparam logic [15:0] THRESHOLD_MID_RST  = 16'd10;
	localparam logic [15:0] THRESHOLD_LOW_RST  = 16'd2;
	localparam logic [3:0]  FILTER_SHIFT_RST   = 4'd3;
	localparam logic [7:0]  AGE_LIMIT_RST      = 8'd10;
	localparam logic [31:0] COST_TABLE_RST     = 32'd268698113;

	// worst quality class
	localparam logic [1:0] CLASS_WORST = 2'd3;

	// input request payload
	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  neighbor;
		logic [15:0] link_margin;
		logic [1:0]  reported_quality;
		logic [3:0]  next_hop;
		logic [7:0]  route_cost;
	} lqt_in_t;

	// result payload
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  neighbor_id;
		logic [1:0]  in_quality;
		logic [7:0]  in_cost;
		logic [7:0]  out_cost;
		logic [15:0] average_whole;
		logic [15:0] expired_mask;
		logic [3:0]  hop_read;
		logic [7:0]  cost_read;
	} lqt_out_t;

	// classified command between front and back
	typedef struct packed {
		lqt_in_t item;
		logic    in_range;
	} lqt_cmd_t;

	// configuration bundle
	typedef struct packed {
		logic [15:0] threshold_high;
		logic [15:0] threshold_mid;
		logic [15:0] threshold_low;
		logic [3:0]  filter_shift;
		logic [7:0]  age_limit;
		logic [31:0] cost_table;
	} lqt_cfg_t;

	// sort the whole part of the average into a class, 0 best
	function automatic logic [1:0] classify(input logic [15:0] whole, input lqt_cfg_t cfg);
		logic [1:0] cls;
		if (whole > cfg.threshold_high) cls = 2'd0;
		else if (whole > cfg.threshold_mid) cls = 2'd1;
		else if (whole > cfg.threshold_low) cls = 2'd2;
		else cls = CLASS_WORST;
		return cls;
	endfunction

	// cost byte of a class
	function automatic logic [7:0] class_cost(input logic [31:0] table_w, input logic [1:0] cls);
		return table_w[8*cls +: 8];
	endfunction

endpackage

`default_nettype wire

// ----- src/lqt_fifo.sv -----
// small first-in first-out queue of generic payload type
`default_nettype none

module lqt_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = lqt_pkg::QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire T     wr_data,
	output logic      full,
	input  wire logic rd_en,
	output T          rd_data,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- src/lqt_front.sv -----
// front end: accepts requests, range-checks the index, queues commands
`default_nettype none

module lqt_front #(
	parameter int NEIGHBOR_COUNT = lqt_pkg::NEIGHBOR_COUNT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lqt_pkg::lqt_in_t item,
	output logic                  full,
	output logic                  cmd_valid,
	input  wire logic             cmd_take,
	output lqt_pkg::lqt_cmd_t     cmd
);

	lqt_pkg::lqt_cmd_t cmd_in;
	logic              cmd_empty;

	// classify the index against the table size
	always_comb begin
		cmd_in.item     = item;
		cmd_in.in_range = ({28'd0, item.neighbor} < 32'(NEIGHBOR_COUNT));
	end

	// command queue toward the back end
	lqt_fifo #(
		.T     (lqt_pkg::lqt_cmd_t),
		.DEPTH (lqt_pkg::QUEUE_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_take),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ----- src/lqt_back.sv -----
// back end: neighbor and route tables, filter, classing, aging
`default_nettype none

module lqt_back #(
	parameter int NEIGHBOR_COUNT = lqt_pkg::NEIGHBOR_COUNT,
	parameter int FRACTION_BITS  = lqt_pkg::FRACTION_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lqt_pkg::lqt_cfg_t cfg,
	input  wire logic              cmd_valid,
	input  wire lqt_pkg::lqt_cmd_t cmd,
	output logic                   cmd_take,
	input  wire logic              res_full,
	output logic                   res_push,
	output lqt_pkg::lqt_out_t      res
);

	localparam int IDX_W   = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;
	localparam int AVG_W   = lqt_pkg::MARGIN_W + FRACTION_BITS;
	localparam int SUM_W   = AVG_W + 1;
	localparam int MASK_W  = lqt_pkg::MASK_W;
	localparam int MASK_N  = (NEIGHBOR_COUNT < MASK_W) ? NEIGHBOR_COUNT : MASK_W;

	typedef enum logic {
		ST_IDLE,
		ST_FINISH
	} state_t;

	state_t state_q;

	// neighbor and route tables
	logic [AVG_W-1:0] avg_q   [NEIGHBOR_COUNT];
	logic [7:0]       age_q   [NEIGHBOR_COUNT];
	logic [3:0]       hop_q   [NEIGHBOR_COUNT];
	logic [7:0]       price_q [NEIGHBOR_COUNT];

	// stage one registers
	lqt_pkg::lqt_cmd_t cmd_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [AVG_W-1:0]  avg_s1;

	logic [IDX_W-1:0]          idx_take;
	logic [AVG_W-1:0]          avg_rd;
	logic [AVG_W-1:0]          margin_term;
	logic [SUM_W-1:0]          avg_sum;
	logic [AVG_W-1:0]          avg_nx;
	logic [15:0]               whole;
	logic [1:0]                cls;
	logic [NEIGHBOR_COUNT-1:0] live;
	logic [NEIGHBOR_COUNT-1:0] expired;
	logic [NEIGHBOR_COUNT-1:0] route_clear;
	logic [MASK_W-1:0]         expired_mask;
	logic                      is_report;
	logic                      is_tick;
	logic                      is_route_wr;

	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;
	assign res_push = (state_q == ST_FINISH) && !res_full;

	assign is_report   = (cmd_s1.item.operation == lqt_pkg::OP_REPORT);
	assign is_tick     = (cmd_s1.item.operation == lqt_pkg::OP_TICK);
	assign is_route_wr = (cmd_s1.item.operation == lqt_pkg::OP_ROUTE_WRITE);

	// stage one: read the average and run the shift filter
	always_comb begin
		idx_take    = cmd.in_range ? IDX_W'(cmd.item.neighbor) : '0;
		avg_rd      = avg_q[idx_take];
		margin_term = (AVG_W'(cmd.item.link_margin) << FRACTION_BITS) >> cfg.filter_shift;
		avg_sum     = SUM_W'(avg_rd) - SUM_W'(avg_rd >> cfg.filter_shift) + SUM_W'(margin_term);
		avg_nx      = avg_sum[AVG_W-1:0];
	end

	// stage two: class of the new average
	always_comb begin
		whole = avg_s1[AVG_W-1:FRACTION_BITS];
		cls   = lqt_pkg::classify(whole, cfg);
	end

	// aging: each neighbor judged on its own old age
	always_comb begin
		for (int n = 0; n < NEIGHBOR_COUNT; n++) begin
			live[n]    = (age_q[n] != 8'd0);
			expired[n] = live[n] && (age_q[n] >= cfg.age_limit);
		end
	end

	// routes whose next hop timed out
	always_comb begin
		logic [IDX_W-1:0] hop_idx;
		logic             hop_ok;
		for (int r = 0; r < NEIGHBOR_COUNT; r++) begin
			hop_ok         = ({28'd0, hop_q[r]} < 32'(NEIGHBOR_COUNT));
			hop_idx        = hop_ok ? IDX_W'(hop_q[r]) : '0;
			route_clear[r] = hop_ok && expired[hop_idx];
		end
	end

	// mask bits exist only for the first sixteen neighbors
	always_comb begin
		expired_mask = '0;
		for (int n = 0; n < MASK_N; n++) begin
			expired_mask[n] = expired[n];
		end
	end

	// result assembly
	always_comb begin
		res             = '0;
		res.kind        = cmd_s1.item.operation;
		res.neighbor_id = cmd_s1.item.neighbor;
		if (is_tick) begin
			res.expired_mask = expired_mask;
		end else if (cmd_s1.in_range) begin
			if (is_report) begin
				res.in_quality    = cls;
				res.in_cost       = lqt_pkg::class_cost(cfg.cost_table, cls);
				res.out_cost      = lqt_pkg::class_cost(cfg.cost_table,
					cmd_s1.item.reported_quality);
				res.average_whole = whole;
			end else if (is_route_wr) begin
				res.hop_read  = cmd_s1.item.next_hop;
				res.cost_read = cmd_s1.item.route_cost;
			end else begin
				res.hop_read  = hop_q[idx_s1];
				res.cost_read = price_q[idx_s1];
			end
		end
	end

	// sequencer: take a command, then commit and hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (res_push) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stage one capture
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1 <= cmd;
			idx_s1 <= idx_take;
			avg_s1 <= avg_nx;
		end
	end

	// table updates at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NEIGHBOR_COUNT; n++) begin
				avg_q[n]   <= '0;
				age_q[n]   <= '0;
				hop_q[n]   <= '0;
				price_q[n] <= '0;
			end
		end else if (res_push) begin
			if (is_tick) begin
				for (int n = 0; n < NEIGHBOR_COUNT; n++) begin
					if (expired[n]) begin
						avg_q[n] <= '0;
						age_q[n] <= '0;
					end else if (live[n] && (age_q[n] != 8'hFF)) begin
						age_q[n] <= age_q[n] + 8'd1;
					end
					if (route_clear[n]) begin
						hop_q[n]   <= '0;
						price_q[n] <= '0;
					end
				end
			end else if (cmd_s1.in_range) begin
				if (is_report) begin
					avg_q[idx_s1] <= avg_s1;
					age_q[idx_s1] <= 8'd1;
				end else if (is_route_wr) begin
					hop_q[idx_s1]   <= cmd_s1.item.next_hop;
					price_q[idx_s1] <= cmd_s1.item.route_cost;
				end
			end
		end
	end

	// a taken command is always followed by the commit state
	a_take_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> state_q == ST_FINISH)
		else $error("command taken without moving to commit");

	// a committed report leaves its neighbor live with age one
	a_report_age: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && is_report && cmd_s1.in_range) |=> age_q[idx_s1] == 8'd1)
		else $error("report did not restart neighbor age");

	// a committed route write is visible in the table
	a_route_written: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && is_route_wr && cmd_s1.in_range) |=>
			(hop_q[idx_s1] == cmd_s1.item.next_hop) &&
			(price_q[idx_s1] == cmd_s1.item.route_cost))
		else $error("route write lost");

	// an out-of-range index yields no table data
	a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !cmd_s1.in_range && !is_tick) |->
			(res.average_whole == '0) && (res.hop_read == '0) &&
			(res.cost_read == '0) && (res.in_cost == '0))
		else $error("out-of-range request produced table data");

	// only live neighbors can time out
	a_expire_live_only: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && is_tick) |-> ((expired & ~live) == '0))
		else $error("idle neighbor reported as timed out");

endmodule

`default_nettype wire

// ----- src/link_quality_table.sv -----
// top level of the link quality table: configuration registers and queues
//
//  channel   handshake               payload
//  --------  ----------------------  ----------------------------------
//  request   push / full             item   (lqt_in_t)
//  result    pop / empty             result (lqt_out_t)
//  config    cfg_valid / cfg_ready   cfg_index (3 bits), cfg_data (32 bits)
//
// the execution engine reads and filters the neighbor average when it takes a
// request, then classes it and commits the table update in its finish state
// a tick ages all live neighbors, clears dependent routes in its commit cycle
// reset clears tables and queues and presets config at once; no clearing pass
// two-entry queues sit on both sides; full rises when the request queue holds
// two commands, and the engine holds its commit while the result queue is full
`default_nettype none

module link_quality_table #(
	parameter int NEIGHBOR_COUNT = lqt_pkg::NEIGHBOR_COUNT,
	parameter int FRACTION_BITS  = lqt_pkg::FRACTION_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire lqt_pkg::lqt_in_t                item,
	output logic                                 full,
	input  wire logic                            pop,
	output lqt_pkg::lqt_out_t                    result,
	output logic                                 empty,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lqt_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                     cfg_data
);

	lqt_pkg::lqt_cfg_t cfg_q;
	lqt_pkg::lqt_cmd_t cmd;
	lqt_pkg::lqt_out_t res;
	logic              cmd_valid;
	logic              cmd_take;
	logic              res_push;
	logic              res_full;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_high <= lqt_pkg::THRESHOLD_HIGH_RST;
			cfg_q.threshold_mid  <= lqt_pkg::THRESHOLD_MID_RST;
			cfg_q.threshold_low  <= lqt_pkg::THRESHOLD_LOW_RST;
			cfg_q.filter_shift   <= lqt_pkg::FILTER_SHIFT_RST;
			cfg_q.age_limit      <= lqt_pkg::AGE_LIMIT_RST;
			cfg_q.cost_table     <= lqt_pkg::COST_TABLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lqt_pkg::REG_THRESHOLD_HIGH: cfg_q.threshold_high <= cfg_data[15:0];
				lqt_pkg::REG_THRESHOLD_MID:  cfg_q.threshold_mid  <= cfg_data[15:0];
				lqt_pkg::REG_THRESHOLD_LOW:  cfg_q.threshold_low  <= cfg_data[15:0];
				lqt_pkg::REG_FILTER_SHIFT:   cfg_q.filter_shift   <= cfg_data[3:0];
				lqt_pkg::REG_AGE_LIMIT:      cfg_q.age_limit      <= cfg_data[7:0];
				lqt_pkg::REG_COST_TABLE:     cfg_q.cost_table     <= cfg_data;
				default: ;
			endcase
		end
	end

	// request intake and command queue
	lqt_front #(
		.NEIGHBOR_COUNT (NEIGHBOR_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	// execution engine
	lqt_back #(
		.NEIGHBOR_COUNT (NEIGHBOR_COUNT),
		.FRACTION_BITS  (FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue
	lqt_fifo #(
		.T     (lqt_pkg::lqt_out_t),
		.DEPTH (lqt_pkg::QUEUE_DEPTH)
	) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

`default_nettype wire

// ----- sim/lqt_checker.sv -----
// link quality table checker: tracks the tables, predicts answers and compares them
`timescale 1ns / 1ps

module lqt_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire lqt_pkg::lqt_in_t              item,
	input  wire logic                          full,
	input  wire logic                          pop,
	input  wire lqt_pkg::lqt_out_t             result,
	input  wire logic                          empty,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [lqt_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	output int                                 fail_count,
	output int                                 outstanding
);
	import lqt_pkg::*;

	localparam logic [1:0] CLASS_BEST = 2'd0;
	localparam logic [1:0] CLASS_GOOD = 2'd1;
	localparam logic [1:0] CLASS_FAIR = 2'd2;

	// shadow copy of the neighbor and route tables
	logic [15+FRACTION_BITS:0] avg_fx    [NEIGHBOR_COUNT];
	logic [1:0]                rx_class  [NEIGHBOR_COUNT];
	logic [1:0]                tx_class  [NEIGHBOR_COUNT];
	logic [7:0]                link_age  [NEIGHBOR_COUNT];
	logic [3:0]                hop_tab   [NEIGHBOR_COUNT];
	logic [7:0]                price_tab [NEIGHBOR_COUNT];
	lqt_cfg_t                  cfg_m;

	// answers owed by the block, oldest first
	lqt_out_t table_answers[$];
	int       errs = 0;

	// apply one request to the shadow tables and build its answer
	task automatic apply_to_table(input lqt_in_t rq, output lqt_out_t ans);
		logic [31:0] acc;
		logic [15:0] whole;
		logic [1:0]  cls;
		int          idx;
		int          n;
		int          r;
		ans             = '0;
		ans.kind        = rq.operation;
		ans.neighbor_id = rq.neighbor;
		idx             = int'(rq.neighbor);
		case (rq.operation)
			OP_REPORT: begin
				acc = 32'(avg_fx[idx]);
				acc = acc - (acc >> cfg_m.filter_shift)
					+ ((32'(rq.link_margin) << FRACTION_BITS) >> cfg_m.filter_shift);
				avg_fx[idx] = acc[15+FRACTION_BITS:0];
				whole = acc[FRACTION_BITS +: 16];
				// strict compares, best class first
				if (whole > cfg_m.threshold_high) cls = CLASS_BEST;
				else if (whole > cfg_m.threshold_mid) cls = CLASS_GOOD;
				else if (whole > cfg_m.threshold_low) cls = CLASS_FAIR;
				else cls = CLASS_WORST;
				rx_class[idx]     = cls;
				tx_class[idx]     = rq.reported_quality;
				link_age[idx]     = 8'd1;
				ans.in_quality    = cls;
				ans.in_cost       = cfg_m.cost_table[8*cls +: 8];
				ans.out_cost      = cfg_m.cost_table[8*rq.reported_quality +: 8];
				ans.average_whole = whole;
			end
			OP_TICK: begin
				// old age decides the timeout, then live neighbors grow older
				for (n = 0; n < NEIGHBOR_COUNT; n++) begin
					if (link_age[n] != 8'd0) begin
						if (link_age[n] >= cfg_m.age_limit) begin
							link_age[n]         = 8'd0;
							avg_fx[n]           = '0;
							rx_class[n]         = CLASS_WORST;
							tx_class[n]         = CLASS_WORST;
							ans.expired_mask[n] = 1'b1;
							for (r = 0; r < NEIGHBOR_COUNT; r++) begin
								if (hop_tab[r] == 4'(n)) begin
									hop_tab[r]   = 4'd0;
									price_tab[r] = 8'd0;
								end
							end
						end else if (link_age[n] != 8'hFF) begin
							link_age[n] = link_age[n] + 8'd1;
						end
					end
				end
			end
			default: begin
				if (rq.operation == OP_ROUTE_WRITE) begin
					hop_tab[idx]   = rq.next_hop;
					price_tab[idx] = rq.route_cost;
				end
				ans.hop_read  = hop_tab[idx];
				ans.cost_read = price_tab[idx];
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errs++;
		end
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin : watch
		lqt_out_t want;
		lqt_out_t fresh;
		int       i;
		if (!arst_n) begin
			for (i = 0; i < NEIGHBOR_COUNT; i++) begin
				avg_fx[i]    = '0;
				rx_class[i]  = CLASS_WORST;
				tx_class[i]  = CLASS_WORST;
				link_age[i]  = 8'd0;
				hop_tab[i]   = 4'd0;
				price_tab[i] = 8'd0;
			end
			cfg_m.threshold_high = THRESHOLD_HIGH_RST;
			cfg_m.threshold_mid  = THRESHOLD_MID_RST;
			cfg_m.threshold_low  = THRESHOLD_LOW_RST;
			cfg_m.filter_shift   = FILTER_SHIFT_RST;
			cfg_m.age_limit      = AGE_LIMIT_RST;
			cfg_m.cost_table     = COST_TABLE_RST;
			table_answers.delete();
		end else begin
			// results first: an answer leaving now is never for a request arriving now
			if (pop && !empty) begin
				if (table_answers.size() == 0) begin
					$display("%0t: unexpected answer, expected none, actual %p", $time, result);
					errs++;
				end else begin
					want = table_answers.pop_front();
					check_field("kind", 32'(want.kind), 32'(result.kind));
					check_field("neighbor_id", 32'(want.neighbor_id),
						32'(result.neighbor_id));
					check_field("in_quality", 32'(want.in_quality),
						32'(result.in_quality));
					check_field("in_cost", 32'(want.in_cost), 32'(result.in_cost));
					check_field("out_cost", 32'(want.out_cost), 32'(result.out_cost));
					check_field("average_whole", 32'(want.average_whole),
						32'(result.average_whole));
					check_field("expired_mask", 32'(want.expired_mask),
						32'(result.expired_mask));
					check_field("hop_read", 32'(want.hop_read), 32'(result.hop_read));
					check_field("cost_read", 32'(want.cost_read), 32'(result.cost_read));
				end
			end
			if (push && !full) begin
				apply_to_table(item, fresh);
				table_answers.push_back(fresh);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESHOLD_HIGH: cfg_m.threshold_high = cfg_data[15:0];
					REG_THRESHOLD_MID:  cfg_m.threshold_mid  = cfg_data[15:0];
					REG_THRESHOLD_LOW:  cfg_m.threshold_low  = cfg_data[15:0];
					REG_FILTER_SHIFT:   cfg_m.filter_shift   = cfg_data[3:0];
					REG_AGE_LIMIT:      cfg_m.age_limit      = cfg_data[7:0];
					REG_COST_TABLE:     cfg_m.cost_table     = cfg_data;
					default: ;
				endcase
			end
		end
		fail_count  <= errs;
		outstanding <= table_answers.size();
	end

endmodule

// ----- sim/link_quality_table_tb.sv -----
// link quality table testbench top: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module link_quality_table_tb;
	import lqt_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 200;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	lqt_in_t              item;
	logic                 full;
	logic                 pop;
	lqt_out_t             result;
	logic                 empty;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	int                   fails;
	int                   outstanding;

	int   send_idle_pct = 0;
	int   stall_pct = 0;
	logic hold_rx = 1'b0;
	int   quiet_cycles = 0;

	link_quality_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.pop       (pop),
		.result    (result),
		.empty     (empty),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lqt_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.item        (item),
		.full        (full),
		.pop         (pop),
		.result      (result),
		.empty       (empty),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fails),
		.outstanding (outstanding)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		pop <= arst_n && !hold_rx && ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic lqt_in_t req(input logic [1:0] op, input logic [3:0] n,
			input logic [15:0] margin, input logic [1:0] rq, input logic [3:0] hop,
			input logic [7:0] price);
		lqt_in_t r;
		r.operation        = op;
		r.neighbor         = n;
		r.link_margin      = margin;
		r.reported_quality = rq;
		r.next_hop         = hop;
		r.route_cost       = price;
		return r;
	endfunction

	// reports most often, mostly on a few hot neighbors, so averages settle and ages run out
	function automatic lqt_in_t random_request();
		lqt_in_t r;
		int      roll;
		roll = $urandom_range(99);
		if (roll < 45) r.operation = OP_REPORT;
		else if (roll < 65) r.operation = OP_TICK;
		else if (roll < 82) r.operation = OP_ROUTE_WRITE;
		else r.operation = OP_ROUTE_READ;
		r.neighbor = ($urandom_range(99) < 65) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
		roll = $urandom_range(99);
		if (roll < 15) r.link_margin = 16'd0;
		else if (roll < 25) r.link_margin = 16'hFFFF;
		else if (roll < 65) r.link_margin = 16'($urandom_range(63));
		else r.link_margin = 16'($urandom);
		r.reported_quality = 2'($urandom_range(3));
		r.next_hop   = ($urandom_range(99) < 50) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
		r.route_cost = 8'($urandom);
		return r;
	endfunction

	// offer one request and wait until it is taken; push stays high for the next one
	task automatic send_request(input lqt_in_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= r;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic random_batch(input int count);
		repeat (count) send_request(random_request());
	endtask

	// stop offering and wait for every owed answer
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] hi, input logic [15:0] mid,
			input logic [15:0] lo, input logic [3:0] shift, input logic [7:0] age_max,
			input logic [31:0] costs);
		drain();
		write_reg(REG_THRESHOLD_HIGH, 32'(hi));
		write_reg(REG_THRESHOLD_MID, 32'(mid));
		write_reg(REG_THRESHOLD_LOW, 32'(lo));
		write_reg(REG_FILTER_SHIFT, 32'(shift));
		write_reg(REG_AGE_LIMIT, 32'(age_max));
		write_reg(REG_COST_TABLE, costs);
		cfg_valid <= 1'b0;
	endtask

	// main sequence
	initial begin
		logic [15:0] lo;
		logic [15:0] mid;
		logic [15:0] hi;
		arst_n    = 1'b0;
		push      = 1'b0;
		item      = '0;
		pop       = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: route table extremes, margin extremes, plain aging
		send_request(req(OP_ROUTE_WRITE, 4'd0, 16'd0, 2'd0, 4'd5, 8'hFF));
		send_request(req(OP_ROUTE_WRITE, 4'd15, 16'hFFFF, 2'd3, 4'd15, 8'hA5));
		send_request(req(OP_ROUTE_READ, 4'd0, 16'd0, 2'd0, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd5, 16'hFFFF, 2'd0, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd0, 16'd0, 2'd3, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd15, 16'd16, 2'd1, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd15, 16'd16, 2'd2, 4'd0, 8'd0));
		send_request(req(OP_TICK, 4'd9, 16'd0, 2'd0, 4'd0, 8'd0));
		send_request(req(OP_ROUTE_READ, 4'd15, 16'd0, 2'd0, 4'd0, 8'd0));

		// age limit zero: every live neighbor times out and its routes clear
		set_config(THRESHOLD_HIGH_RST, THRESHOLD_MID_RST, THRESHOLD_LOW_RST,
			FILTER_SHIFT_RST, 8'd0, COST_TABLE_RST);
		send_request(req(OP_TICK, 4'd0, 16'd0, 2'd0, 4'd0, 8'd0));
		send_request(req(OP_ROUTE_READ, 4'd0, 16'd0, 2'd0, 4'd0, 8'd0));
		send_request(req(OP_ROUTE_READ, 4'd15, 16'd0, 2'd0, 4'd0, 8'd0));

		// shift zero: average equals margin, so thresholds are hit exactly
		set_config(16'd100, 16'd50, 16'd10, 4'd0, 8'd1, 32'h4030_2010);
		send_request(req(OP_REPORT, 4'd3, 16'd101, 2'd0, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd3, 16'd100, 2'd1, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd3, 16'd50, 2'd2, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd3, 16'd11, 2'd3, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd3, 16'd10, 2'd0, 4'd0, 8'd0));
		send_request(req(OP_TICK, 4'd3, 16'd0, 2'd0, 4'd0, 8'd0));

		// widest shift, high and mid thresholds at the top, low at zero, zero costs
		set_config(16'hFFFF, 16'hFFFF, 16'd0, 4'd15, 8'd255, 32'd0);
		send_request(req(OP_REPORT, 4'd7, 16'hFFFF, 2'd3, 4'd0, 8'd0));
		send_request(req(OP_REPORT, 4'd7, 16'hFFFF, 2'd1, 4'd0, 8'd0));
		send_request(req(OP_ROUTE_WRITE, 4'd7, 16'd0, 2'd0, 4'd7, 8'd0));
		send_request(req(OP_ROUTE_READ, 4'd7, 16'd0, 2'd0, 4'd0, 8'd0));
		send_request(req(OP_TICK, 4'd7, 16'd0, 2'd0, 4'd0, 8'd0));

		// random phases, one setting each
		set_config(THRESHOLD_HIGH_RST, THRESHOLD_MID_RST, THRESHOLD_LOW_RST,
			FILTER_SHIFT_RST, AGE_LIMIT_RST, COST_TABLE_RST);
		random_batch(250);

		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 8'd255, 32'hFFFF_FFFF);
		send_idle_pct = 83;
		random_batch(200);

		set_config(16'd0, 16'd0, 16'd0, 4'd0, 8'd1, 32'd0);
		send_idle_pct = 0;
		stall_pct     = 83;
		random_batch(200);

		set_config(16'($urandom), 16'($urandom), 16'($urandom), 4'($urandom_range(15)),
			8'($urandom_range(1, 6)), $urandom);
		send_idle_pct = 25;
		stall_pct     = 25;
		random_batch(250);

		// receiver holds off while requests keep coming, so the block backs up
		set_config(16'd300, 16'd100, 16'd20, 4'd2, 8'd3, $urandom);
		send_idle_pct = 0;
		stall_pct     = 0;
		fork
			begin
				repeat (30) @(posedge clk);
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
			random_batch(250);
		join

		set_config(16'd40, 16'd20, 16'd5, 4'd1, 8'd0, $urandom);
		send_idle_pct = 25;
		stall_pct     = 25;
		random_batch(200);

		lo  = 16'($urandom_range(20));
		mid = lo + 16'($urandom_range(20));
		hi  = mid + 16'($urandom_range(30));
		set_config(hi, mid, lo, 4'($urandom_range(15)), 8'($urandom_range(2, 8)), $urandom);
		send_idle_pct = 0;
		stall_pct     = 0;
		random_batch(300);

		lo  = 16'($urandom_range(10));
		mid = lo + 16'($urandom_range(40));
		hi  = mid + 16'($urandom);
		set_config(hi, mid, lo, 4'($urandom_range(4)), 8'($urandom_range(1, 5)), $urandom);
		send_idle_pct = 83;
		stall_pct     = 83;
		random_batch(300);

		// wind down and give the verdict
		drain();
		repeat (8) @(posedge clk);
		if (fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
